// ===== rtl/core/gdr_pkg.sv =====
// ============================================================================
// gdr_pkg: shared types and constants of the grid DDA ray caster
// Field widths, fixed point constants, register indexes and the result type.
// ============================================================================
`default_nettype none

package gdr_pkg;

    // payload field widths
    localparam int PosW     = 14;   // unsigned Q6.8 position
    localparam int HeadW    = 16;   // signed Q2.14 direction
    localparam int DistW    = 16;   // Q8.8 distance
    localparam int TagW     = 4;
    localparam int CellW    = 6;
    localparam int UW       = 8;    // Q0.8 wall coordinate

    // configuration port
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 16;
    localparam logic [CfgIdxW-1:0] CfgRenderLimit = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgIgnoreMask  = CfgIdxW'(1);
    localparam logic [CfgDataW-1:0] LimitReset    = 16'd4096;
    localparam logic [CfgDataW-1:0] MaskReset     = 16'd1;

    // request kinds
    localparam logic ReqWrite = 1'b0;
    localparam logic ReqCast  = 1'b1;

    // internal datapath widths
    localparam int SideW    = DistW + 1;    // side distances, one carry bit
    localparam int MulW     = 17;           // signed multiplier operands
    localparam int ProdW    = 2 * MulW;

    // tags at or above this count are never passed through
    localparam int TagCount  = 16;
    localparam int MapDimDef = 64;

    // reciprocal 2^22 / a: quotients of divisors up to RecipSmall saturate
    localparam logic [DistW-1:0] DeltaMax   = 16'hFFFF;
    localparam logic [DistW-1:0] RecipSmall = 16'd64;
    localparam logic [DistW-1:0] RecipRem0  = 16'd64;   // 2^22 >> 16

    typedef struct packed {
        logic             no_hit;
        logic             hit_side;
        logic [TagW-1:0]  hit_tag;
        logic [DistW-1:0] ray_distance;
        logic [DistW-1:0] perp_distance;
        logic [UW-1:0]    wall_u;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/gdr_if.sv =====
// ============================================================================
// gdr_if: channel interfaces of the grid DDA ray caster
// Request, result and configuration channels, each with valid and ready.
// ============================================================================
`default_nettype none

interface gdr_req_if import gdr_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [CellW-1:0]         cell_row;
    logic [CellW-1:0]         cell_col;
    logic [TagW-1:0]          cell_tag;
    logic [PosW-1:0]          start_x;
    logic [PosW-1:0]          start_y;
    logic signed [HeadW-1:0]  heading_x;
    logic signed [HeadW-1:0]  heading_y;

    modport source (output valid, req_type, cell_row, cell_col, cell_tag,
                    start_x, start_y, heading_x, heading_y, input ready);
    modport sink   (input valid, req_type, cell_row, cell_col, cell_tag,
                    start_x, start_y, heading_x, heading_y, output ready);
endinterface

interface gdr_res_if import gdr_pkg::*;;
    logic             valid;
    logic             ready;
    logic             no_hit;
    logic             hit_side;
    logic [TagW-1:0]  hit_tag;
    logic [DistW-1:0] ray_distance;
    logic [DistW-1:0] perp_distance;
    logic [UW-1:0]    wall_u;

    modport source (output valid, no_hit, hit_side, hit_tag, ray_distance,
                    perp_distance, wall_u, input ready);
    modport sink   (input valid, no_hit, hit_side, hit_tag, ray_distance,
                    perp_distance, wall_u, output ready);
endinterface

interface gdr_cfg_if import gdr_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gdr_map.sv =====
// ============================================================================
// gdr_map: tile map memory
// One write and one registered read port; zeroed by a sweep after reset.
// ============================================================================
`default_nettype none

module gdr_map import gdr_pkg::*; #(
    parameter int MAP_DIM = MapDimDef
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_wr_en,
    input  wire logic [$clog2(MAP_DIM*MAP_DIM)-1:0]    i_wr_addr,
    input  wire logic [TagW-1:0]                       i_wr_data,
    input  wire logic                                  i_rd_en,
    input  wire logic [$clog2(MAP_DIM*MAP_DIM)-1:0]    i_rd_addr,
    output      logic [TagW-1:0]                       o_rd_data,
    output      logic                                  o_clearing
);
    localparam int Depth = MAP_DIM * MAP_DIM;
    localparam int AW    = $clog2(Depth);
    localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

    logic [TagW-1:0] mem [Depth];
    logic            r_clr_busy;
    logic [AW-1:0]   r_clr_addr;
    logic [TagW-1:0] r_rd_data;

    // clearing sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LastAddr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // storage: sweep writes zero, else item writes
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clr_busy;
endmodule

`default_nettype wire

// ===== rtl/core/gdr_recip.sv =====
// ============================================================================
// gdr_recip: serial reciprocal unit
// Computes min(2^22 / a, 65535) one quotient bit per cycle.
// ============================================================================
`default_nettype none

module gdr_recip import gdr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DistW-1:0]  i_divisor,
    output      logic              o_done,
    output      logic [DistW-1:0]  o_quot
);
    logic             r_busy;
    logic             r_done;
    logic [3:0]       r_cnt;
    logic [DistW-1:0] r_div;
    logic [DistW-1:0] r_rem;
    logic [DistW-1:0] r_quot;
    logic [DistW:0]   trial;
    logic             fits;

    // one restoring step: shift in a zero dividend bit, try to subtract
    assign trial = {r_rem, 1'b0};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_div  <= i_divisor;
                r_rem  <= RecipRem0;
                r_cnt  <= '0;
                // small divisors (and zero) saturate at once
                if (i_divisor <= RecipSmall) begin
                    r_quot <= DeltaMax;
                    r_done <= 1'b1;
                end else begin
                    r_quot <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= fits ? DistW'(trial - {1'b0, r_div}) : DistW'(trial);
                r_quot <= {r_quot[DistW-2:0], fits};
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

`default_nettype wire

// ===== rtl/core/grid_dda_ray_caster.sv =====
// ============================================================================
// grid_dda_ray_caster: tile map DDA ray caster
// Sequencer walking the map cell by cell with a shared multiplier and divider.
// ============================================================================
// Usage:
//   i_req  request channel. req_type 0 writes cell_tag into the map cell at
//          (cell_row, cell_col); it gives no result.
//          req_type 1 casts a ray from (start_x, start_y) along the heading.
//   o_res  one result item per cast: tag, side, distances and wall u, or
//          no_hit when the render limit is reached or the ray leaves the map.
//   i_cfg  register writes (render limit, ignore mask), always ready.
// A cast runs a setup (two reciprocals on the shared divider, which finish
// at once when the heading saturates, then two products on the shared
// multiplier), then a step, a bound check with map read and a tag test
// per map cell walked, then the perpendicular distance and wall u, and
// then a load of the output register.
// A start outside the map skips setup and walk. One cast is in flight at a
// time; i_req.ready is low while it runs.
// After reset the map is swept to zero, and no request is taken during
// the sweep. Results sit in an output register; a stalled receiver holds
// the next cast at its end, and no request is taken until it is freed.
// ============================================================================
`default_nettype none

module grid_dda_ray_caster import gdr_pkg::*; #(
    parameter int MAP_DIM = MapDimDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gdr_req_if.sink   i_req,
    gdr_res_if.source o_res,
    gdr_cfg_if.sink   i_cfg
);
    localparam int CI = $clog2(MAP_DIM);
    localparam int CW = CI + 2;
    localparam int AW = $clog2(MAP_DIM * MAP_DIM);
    localparam logic signed [CW-1:0] DimS = CW'(MAP_DIM);

    typedef enum logic [3:0] {
        S_IDLE, S_DIVX, S_DIVY, S_MULX, S_MULY, S_INIT,
        S_STEP, S_LOOK, S_TEST, S_PERP, S_WMUL, S_WALL, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [CfgDataW-1:0] r_limit;
    logic [CfgDataW-1:0] r_mask;

    // ray context
    logic [PosW-1:0]         r_sx, r_sy;
    logic signed [HeadW-1:0] r_hx, r_hy;
    logic [DistW-1:0]        r_dx, r_dy;
    logic [SideW-1:0]        r_side_x, r_side_y, r_dist;
    logic signed [CW-1:0]    r_cx, r_cy;
    logic                    r_side;
    logic [TagW-1:0]         r_tag;
    logic [DistW-1:0]        r_perp;
    t_result                 r_res;
    t_result                 res_init;

    // output register
    logic    r_out_valid;
    t_result r_out;

    // shared multiplier
    logic signed [MulW-1:0]  mul_a, mul_b;
    logic signed [ProdW-1:0] r_prod;

    // datapath helpers
    logic                    req_acc, cast_acc, start_out;
    logic                    rc_start, rc_done;
    logic [DistW-1:0]        rc_divisor, rc_quot;
    logic [8:0]              frac_x, frac_y;
    logic                    take_x, passes, out_free;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic                    wr_en, rd_en, clearing;
    logic [TagW-1:0]         rd_data;
    logic [DistW-1:0]        hit_delta;
    logic [UW-1:0]           u_start;

    // handshakes
    assign i_req.ready = (r_state == S_IDLE) && !clearing;
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && i_req.ready;
    assign cast_acc    = req_acc && (i_req.req_type == ReqCast);
    assign start_out   = (int'(i_req.start_x[PosW-1:8]) >= MAP_DIM) ||
                         (int'(i_req.start_y[PosW-1:8]) >= MAP_DIM);
    assign out_free    = !r_out_valid || o_res.ready;

    // result of a fresh cast: no_hit only when the start is off the map
    always_comb begin
        res_init        = '0;
        res_init.no_hit = start_out;
    end

    // map write and read
    assign wr_en   = req_acc && (i_req.req_type == ReqWrite) &&
                     (int'(i_req.cell_row) < MAP_DIM) && (int'(i_req.cell_col) < MAP_DIM);
    assign wr_addr = AW'(int'(i_req.cell_row) * MAP_DIM + int'(i_req.cell_col));
    assign rd_addr = AW'(int'(r_cy[CI-1:0]) * MAP_DIM + int'(r_cx[CI-1:0]));
    assign rd_en   = (r_state == S_LOOK);

    gdr_map #(.MAP_DIM(MAP_DIM)) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (i_req.cell_tag),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_data  (rd_data),
        .o_clearing (clearing)
    );

    // reciprocal: |hx| at cast accept, |hy| when the first one is done
    assign rc_start   = (cast_acc && !start_out) || ((r_state == S_DIVX) && rc_done);
    assign rc_divisor = (r_state == S_IDLE)
                        ? (i_req.heading_x[HeadW-1] ? DistW'(-i_req.heading_x)
                                                    : DistW'(i_req.heading_x))
                        : (r_hy[HeadW-1] ? DistW'(-r_hy) : DistW'(r_hy));

    gdr_recip u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (rc_start),
        .i_divisor (rc_divisor),
        .o_done    (rc_done),
        .o_quot    (rc_quot)
    );

    // distance to first grid line, in 1/256 cell
    assign frac_x = (r_hx > 0) ? 9'(9'd256 - {1'b0, r_sx[7:0]}) : {1'b0, r_sx[7:0]};
    assign frac_y = (r_hy > 0) ? 9'(9'd256 - {1'b0, r_sy[7:0]}) : {1'b0, r_sy[7:0]};

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MULX: begin
                mul_a = MulW'({8'd0, frac_x});
                mul_b = MulW'({1'b0, r_dx});
            end
            S_MULY: begin
                mul_a = MulW'({8'd0, frac_y});
                mul_b = MulW'({1'b0, r_dy});
            end
            S_WMUL: begin
                mul_a = MulW'({1'b0, r_perp});
                mul_b = r_side ? MulW'(r_hx) : MulW'(r_hy);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // walk helpers
    assign take_x    = r_side_x < r_side_y;
    assign passes    = (int'(rd_data) < TagCount) && r_mask[rd_data];
    assign hit_delta = r_side ? r_dy : r_dx;
    assign u_start   = r_side ? r_sx[UW-1:0] : r_sy[UW-1:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
            r_mask  <= MaskReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CfgRenderLimit: r_limit <= i_cfg.data;
                CfgIgnoreMask:  r_mask  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // output register: load from the sequencer, clear when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out       <= r_res;
            r_out_valid <= 1'b1;
        end else if (o_res.valid && o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (cast_acc) begin
                        r_sx  <= i_req.start_x;
                        r_sy  <= i_req.start_y;
                        r_hx  <= i_req.heading_x;
                        r_hy  <= i_req.heading_y;
                        r_cx  <= CW'(i_req.start_x[PosW-1:8]);
                        r_cy  <= CW'(i_req.start_y[PosW-1:8]);
                        r_res <= res_init;
                        r_state <= start_out ? S_DONE : S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (rc_done) begin
                        r_dx    <= rc_quot;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (rc_done) begin
                        r_dy    <= rc_quot;
                        r_state <= S_MULX;
                    end
                end
                S_MULX: r_state <= S_MULY;
                S_MULY: begin
                    r_side_x <= r_prod[SideW+7:8];
                    r_state  <= S_INIT;
                end
                S_INIT: begin
                    r_side_y <= r_prod[SideW+7:8];
                    r_state  <= S_STEP;
                end
                // advance along the nearer grid line (y on a tie)
                S_STEP: begin
                    if (take_x) begin
                        r_side_x <= SideW'(r_side_x + {1'b0, r_dx});
                        r_dist   <= SideW'(r_side_x + {1'b0, r_dx});
                        r_cx     <= (r_hx > 0) ? r_cx + CW'(1) : r_cx - CW'(1);
                        r_side   <= 1'b0;
                    end else begin
                        r_side_y <= SideW'(r_side_y + {1'b0, r_dy});
                        r_dist   <= SideW'(r_side_y + {1'b0, r_dy});
                        r_cy     <= (r_hy > 0) ? r_cy + CW'(1) : r_cy - CW'(1);
                        r_side   <= 1'b1;
                    end
                    r_state <= S_LOOK;
                end
                // limit first, then map bounds; map read issued here
                S_LOOK: begin
                    if ((r_dist >= {1'b0, r_limit}) || (r_cx < 0) || (r_cx >= DimS) ||
                        (r_cy < 0) || (r_cy >= DimS)) begin
                        r_res.no_hit <= 1'b1;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    r_tag   <= rd_data;
                    r_state <= passes ? S_STEP : S_PERP;
                end
                S_PERP: begin
                    r_perp  <= (r_dist >= {1'b0, hit_delta})
                               ? DistW'(r_dist - {1'b0, hit_delta}) : '0;
                    r_state <= S_WMUL;
                end
                S_WMUL: r_state <= S_WALL;
                // u = low bits of start + floor(perp * heading / 2^14)
                S_WALL: begin
                    r_res.no_hit        <= 1'b0;
                    r_res.hit_side      <= r_side;
                    r_res.hit_tag       <= r_tag;
                    r_res.ray_distance  <= r_dist[SideW-1] ? DeltaMax : r_dist[DistW-1:0];
                    r_res.perp_distance <= r_perp;
                    r_res.wall_u        <= UW'(u_start + r_prod[UW+13:14]);
                    r_state             <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result channel
    assign o_res.valid         = r_out_valid;
    assign o_res.no_hit        = r_out.no_hit;
    assign o_res.hit_side      = r_out.hit_side;
    assign o_res.hit_tag       = r_out.hit_tag;
    assign o_res.ray_distance  = r_out.ray_distance;
    assign o_res.perp_distance = r_out.perp_distance;
    assign o_res.wall_u        = r_out.wall_u;
endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the grid DDA ray caster
// Loads tile maps through write items, casts rays under several render limits
// and ignore masks, and checks every result against a built-in DDA predictor.
// The sender and receiver idle and stall at random over four phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import gdr_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Dim         = 64;
    localparam int IdleLimit   = 20000;    // covers the map sweep after reset
    localparam int RandomItems = 650;

    typedef struct packed {
        logic                    req_type;
        logic [CellW-1:0]        cell_row;
        logic [CellW-1:0]        cell_col;
        logic [TagW-1:0]         cell_tag;
        logic [PosW-1:0]         start_x;
        logic [PosW-1:0]         start_y;
        logic signed [HeadW-1:0] heading_x;
        logic signed [HeadW-1:0] heading_y;
    } t_ray_req;

    // Map copy, registers and pending casts; predicts each hit on acceptance.
    class ray_board;
        logic [TagW-1:0]     tiles [Dim*Dim];
        logic [DistW-1:0]    limit;
        logic [DistW-1:0]    mask;
        t_result             pending [$];
        int                  errors;

        function new();
            foreach (tiles[i]) tiles[i] = '0;
            limit  = LimitReset;
            mask   = MaskReset;
            errors = 0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
            if (idx == CfgRenderLimit) limit = val;
            else if (idx == CfgIgnoreMask) mask = val;
        endfunction

        function longint recip(int h);
            longint a;
            a = (h < 0) ? -h : h;
            if (a == 0) return 65535;
            return (4194304 / a > 65535) ? 65535 : 4194304 / a;
        endfunction

        function logic [UW-1:0] wall_coord(longint start, longint perp, int h);
            longint p, q;
            p = perp * h;
            q = (p >= 0) ? p / 16384 : -((-p + 16383) / 16384);
            return UW'(start + q);
        endfunction

        function void note_item(t_ray_req r);
            longint   sx, sy, dx, dy, side_x, side_y, ray_len, delta, perp;
            int       hx, hy, cx, cy, stx, sty, side;
            logic [TagW-1:0] tag;
            bit       hit;
            t_result  res;
            if (r.req_type == ReqWrite) begin
                tiles[r.cell_row * Dim + r.cell_col] = r.cell_tag;
                return;
            end
            res = '0;
            sx = r.start_x; sy = r.start_y;
            hx = r.heading_x; hy = r.heading_y;
            cx = sx >> 8; cy = sy >> 8;
            if (cx >= Dim || cy >= Dim) begin
                res.no_hit = 1'b1;
                pending.push_back(res);
                return;
            end
            dx = recip(hx); dy = recip(hy);
            stx = (hx > 0) ? 1 : -1;
            sty = (hy > 0) ? 1 : -1;
            side_x = (((hx > 0) ? 256 - (sx & 255) : (sx & 255)) * dx) >> 8;
            side_y = (((hy > 0) ? 256 - (sy & 255) : (sy & 255)) * dy) >> 8;
            hit = 0; side = 0; ray_len = 0; tag = '0;
            // step the axis with the strictly smaller side distance, y on a tie
            forever begin
                if (side_x < side_y) begin
                    side_x += dx; cx += stx; side = 0; ray_len = side_x;
                end else begin
                    side_y += dy; cy += sty; side = 1; ray_len = side_y;
                end
                if (ray_len >= limit) break;
                if (cx < 0 || cx >= Dim || cy < 0 || cy >= Dim) break;
                tag = tiles[cy * Dim + cx];
                if (!mask[tag]) begin
                    hit = 1;
                    break;
                end
            end
            if (!hit) begin
                res.no_hit = 1'b1;
            end else begin
                delta = side ? dy : dx;
                perp  = (ray_len >= delta) ? ray_len - delta : 0;
                res.hit_side      = side[0];
                res.hit_tag       = tag;
                res.ray_distance  = (ray_len > 65535) ? 16'hFFFF : DistW'(ray_len);
                res.perp_distance = (perp > 65535) ? 16'hFFFF : DistW'(perp);
                res.wall_u        = side ? wall_coord(sx, perp, hx)
                                         : wall_coord(sy, perp, hy);
            end
            pending.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gdr_req_if req_ch ();
    gdr_res_if res_ch ();
    gdr_cfg_if cfg_ch ();

    grid_dda_ray_caster dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ray_board board = new();
    int  send_idle_pct = 0;    // chance in a hundred of an idle cycle
    int  recv_stall_pct = 0;
    int  hold_left = 0;        // long receiver hold-off
    int  quiet_cycles = 0;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = ReqWrite;
        req_ch.cell_row = '0; req_ch.cell_col = '0; req_ch.cell_tag = '0;
        req_ch.start_x = '0; req_ch.start_y = '0;
        req_ch.heading_x = '0; req_ch.heading_y = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    // receiver ready, with random stalls and an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result check and watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if (res_ch.valid && res_ch.ready)
            board.check_result({res_ch.no_hit, res_ch.hit_side, res_ch.hit_tag,
                                res_ch.ray_distance, res_ch.perp_distance,
                                res_ch.wall_u});
        if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IdleLimit) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one item, with a random idle gap first
    task automatic send_item(t_ray_req r);
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= r.req_type;
        req_ch.cell_row  <= r.cell_row;
        req_ch.cell_col  <= r.cell_col;
        req_ch.cell_tag  <= r.cell_tag;
        req_ch.start_x   <= r.start_x;
        req_ch.start_y   <= r.start_y;
        req_ch.heading_x <= r.heading_x;
        req_ch.heading_y <= r.heading_y;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_item(r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // register write, only between phases with nothing in flight
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_reg(idx, val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_ray_req tile_write(int row, int col, int tag);
        t_ray_req r;
        r = '0;
        r.req_type = ReqWrite;
        r.cell_row = CellW'(row);
        r.cell_col = CellW'(col);
        r.cell_tag = TagW'(tag);
        return r;
    endfunction

    function automatic t_ray_req ray(int sx, int sy, int hx, int hy);
        t_ray_req r;
        r = '0;
        r.req_type  = ReqCast;
        r.start_x   = PosW'(sx);
        r.start_y   = PosW'(sy);
        r.heading_x = HeadW'(hx);
        r.heading_y = HeadW'(hy);
        return r;
    endfunction

    function automatic int rand_heading();
        case ($urandom_range(5))
            0: return 0;
            1: return $urandom_range(1) ? 16384 : -16384;
            2: return int'($urandom_range(200)) - 100;
            default: return int'($urandom_range(32768)) - 16384;
        endcase
    endfunction

    // mostly casts into a map sprinkled with walls of random tags
    function automatic t_ray_req rand_item();
        if ($urandom_range(99) < 30)
            return tile_write($urandom_range(63), $urandom_range(63),
                              $urandom_range(3) == 0 ? 0 : $urandom_range(15));
        return ray($urandom_range(16383), $urandom_range(16383),
                   rand_heading(), rand_heading());
    endfunction

    initial begin
        logic [CfgDataW-1:0] limits [4];
        logic [CfgDataW-1:0] masks  [4];
        limits = '{16'hFFFF, 16'd0, 16'd1000, 16'(($urandom_range(255) << 8) | 255)};
        masks  = '{16'hFFFF, 16'h0000, 16'h0005, 16'($urandom_range(65535))};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: walls at the edges, all axis directions, extreme headings
        send_item(tile_write(0, 0, 15));
        send_item(tile_write(63, 63, 9));
        send_item(tile_write(32, 40, 3));
        send_item(tile_write(32, 20, 0));
        send_item(ray(16383, 16383, 0, 0));
        send_item(ray(0, 0, -16384, -16384));
        send_item(ray(30 * 256 + 128, 32 * 256 + 128, 16384, 0));
        send_item(ray(30 * 256 + 128, 32 * 256 + 128, -16384, 0));
        send_item(ray(30 * 256, 32 * 256, 0, 16384));
        send_item(ray(30 * 256 + 255, 32 * 256 + 1, 0, -16384));
        send_item(ray(100, 8000, 16384, 16384));
        send_item(ray(16000, 300, -3, 7));
        send_item(ray(5000, 5000, 1, -1));
        send_item(ray(256, 256, -16384, 16384));
        drain();
        write_reg(CfgRenderLimit, 16'hFFFF);
        write_reg(CfgIgnoreMask, 16'h0000);
        write_reg(4'd7, 16'h1234);    // unknown index, ignored
        send_item(ray(30 * 256 + 128, 32 * 256 + 128, 16384, 0));
        send_item(ray(8000, 8000, -16384, 5));
        drain();

        // random phases over different idling and register settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CfgRenderLimit, limits[ph]);
            write_reg(CfgIgnoreMask, masks[ph]);
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 82) : 0;
            recv_stall_pct = (ph == 2) ? 82 : ((ph == 3) ? 12 : 0);
            if (ph == 0) hold_left = 400;
            for (int n = 0; n < RandomItems / 4; n++) send_item(rand_item());
            drain();
        end
        write_reg(CfgRenderLimit, LimitReset);
        write_reg(CfgIgnoreMask, MaskReset);
        for (int n = 0; n < 40; n++) send_item(rand_item());
        drain();

        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/gdr_pkg.sv
rtl/core/gdr_if.sv
rtl/core/gdr_map.sv
rtl/core/gdr_recip.sv
rtl/core/grid_dda_ray_caster.sv
tb/tb_top.sv
